>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 check failed");

// Next-cycle implication, quiet while reset is held.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

>>> sv/sha256md_pkg.sv
`timescale 1ns / 1ps

package sha256md_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned PosW    = 3;
  localparam int unsigned NumHash = 8;
  localparam int unsigned WinLen  = 16;
  localparam int unsigned FillW   = 4;
  localparam int unsigned RoundW  = 6;
  localparam int unsigned LenW    = 64;

  typedef logic [WordW-1:0] word_t;

  localparam word_t HashInit [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control from the sequencer to the message window.
  typedef struct packed {
    logic  push;
    logic  step;
    word_t word;
  } sched_ctl_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic load;
    logic step;
  } round_ctl_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

>>> sv/sha256md_if.sv
`timescale 1ns / 1ps

// Message word channel.
interface sha256md_in_if;
  logic                                valid;
  logic                                ready;
  logic [sha256md_pkg::WordW-1:0]      message_word;
  logic [sha256md_pkg::CountW-1:0]     byte_count;
  logic                                final_word;

  modport source (output valid, message_word, byte_count, final_word, input ready);
  modport sink   (input valid, message_word, byte_count, final_word, output ready);
endinterface

// Digest word channel.
interface sha256md_out_if;
  logic                                valid;
  logic                                ready;
  logic [sha256md_pkg::WordW-1:0]      digest_word;
  logic [sha256md_pkg::PosW-1:0]       word_position;
  logic                                last_of_digest;

  modport source (output valid, digest_word, word_position, last_of_digest, input ready);
  modport sink   (input valid, digest_word, word_position, last_of_digest, output ready);
endinterface

>>> sv/sha256md_sched.sv
`timescale 1ns / 1ps

// Sixteen-word message window: loads block words, then expands the schedule.
module sha256md_sched (
  input  logic                     clk_i,
  input  sha256md_pkg::sched_ctl_t ctl_i,
  output sha256md_pkg::word_t      w_o
);

  sha256md_pkg::word_t win_q [sha256md_pkg::WinLen];
  sha256md_pkg::word_t win_d [sha256md_pkg::WinLen];
  sha256md_pkg::word_t next_w;

  // Form the schedule word sixteen places ahead of the current one.
  assign next_w = sha256md_pkg::small_sigma1(win_q[14]) + win_q[9]
                + sha256md_pkg::small_sigma0(win_q[1]) + win_q[0];

  // Advance the window on a pushed word or a round.
  always_comb begin
    win_d = win_q;
    if (ctl_i.push || ctl_i.step) begin
      for (int i = 0; i < sha256md_pkg::WinLen - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[sha256md_pkg::WinLen-1] = ctl_i.push ? ctl_i.word : next_w;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[0];

endmodule

>>> sv/sha256md_round.sv
`timescale 1ns / 1ps

// Compression round unit: working variables a..h, one round per step.
module sha256md_round (
  input  logic                     clk_i,
  input  sha256md_pkg::round_ctl_t ctl_i,
  input  sha256md_pkg::word_t      init_i [sha256md_pkg::NumHash],
  input  sha256md_pkg::word_t      k_i,
  input  sha256md_pkg::word_t      w_i,
  output sha256md_pkg::word_t      vars_o [sha256md_pkg::NumHash]
);

  sha256md_pkg::word_t v_q [sha256md_pkg::NumHash];
  sha256md_pkg::word_t v_d [sha256md_pkg::NumHash];
  sha256md_pkg::word_t ch, maj, t1, t2;

  // Round function terms.
  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + sha256md_pkg::big_sigma1(v_q[4]) + ch + k_i + w_i;
    t2  = sha256md_pkg::big_sigma0(v_q[0]) + maj;
  end

  // Load from the chaining hash, or rotate through one round.
  always_comb begin
    v_d = v_q;
    if (ctl_i.load) begin
      v_d = init_i;
    end else if (ctl_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign vars_o = v_q;

endmodule

>>> sv/sha256_message_digest.sv
`timescale 1ns / 1ps

// SHA-256 digest of one message per run of input words. Message words are taken only while
// the block waits for input; the sixteenth word of a block starts 64 rounds of the single
// round unit, one per cycle, then a fold into the chaining hash, and input is held off
// during the rounds and the fold. A final word is followed by the padding words (up to 18),
// one or two further compressions and the digest words in order, each held until taken,
// after which the hash is back at its initial values and the next message may start.
module sha256_message_digest (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sha256md_in_if.sink           msg_i,
  sha256md_out_if.source        dig_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_RND,
    S_FOLD,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_80,
    PH_FILL,
    PH_LO,
    PH_DONE
  } phase_e;

  state_e                                state_q, state_d;
  phase_e                                ph_q, ph_d;
  logic                                  fin_q, fin_d;
  logic [sha256md_pkg::FillW-1:0]        fill_q, fill_d;
  logic [sha256md_pkg::LenW-1:0]         len_q, len_d;
  logic [sha256md_pkg::RoundW-1:0]       rnd_q, rnd_d;
  logic [sha256md_pkg::PosW-1:0]         pos_q, pos_d;
  sha256md_pkg::word_t                   h_q [sha256md_pkg::NumHash];
  sha256md_pkg::word_t                   h_d [sha256md_pkg::NumHash];

  sha256md_pkg::sched_ctl_t              sc;
  sha256md_pkg::round_ctl_t              rc;
  sha256md_pkg::word_t                   w_cur;
  sha256md_pkg::word_t                   vars [sha256md_pkg::NumHash];
  sha256md_pkg::word_t                   first_w;
  logic [sha256md_pkg::CountW-1:0]       cnt_sat;
  logic [5:0]                            len_add;

  sha256md_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sc),
    .w_o   (w_cur)
  );

  sha256md_round u_round (
    .clk_i  (clk_i),
    .ctl_i  (rc),
    .init_i (h_q),
    .k_i    (sha256md_pkg::RoundK[rnd_q]),
    .w_i    (w_cur),
    .vars_o (vars)
  );

  // Mask the final word and, when it holds fewer than four bytes, place the padding byte after them.
  always_comb begin
    case (msg_i.byte_count)
      3'd0: begin
        cnt_sat = 3'd0;
        first_w = 32'h8000_0000;
      end
      3'd1: begin
        cnt_sat = 3'd1;
        first_w = {msg_i.message_word[31:24], 24'h80_0000};
      end
      3'd2: begin
        cnt_sat = 3'd2;
        first_w = {msg_i.message_word[31:16], 16'h8000};
      end
      3'd3: begin
        cnt_sat = 3'd3;
        first_w = {msg_i.message_word[31:8], 8'h80};
      end
      default: begin
        cnt_sat = 3'd4;
        first_w = msg_i.message_word;
      end
    endcase
    len_add = msg_i.final_word ? {cnt_sat, 3'b000} : 6'd32;
  end

  // Sequence word loading, padding, rounds, fold and digest output.
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    fin_d   = fin_q;
    fill_d  = fill_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    pos_d   = pos_q;
    h_d     = h_q;
    sc      = '0;
    rc      = '0;

    case (state_q)
      S_IDLE: begin
        if (msg_i.valid) begin
          sc.push = 1'b1;
          sc.word = msg_i.final_word ? first_w : msg_i.message_word;
          fill_d  = fill_q + 1'b1;
          len_d   = len_q + {{(sha256md_pkg::LenW-6){1'b0}}, len_add};
          fin_d   = msg_i.final_word;
          ph_d    = (cnt_sat == 3'd4) ? PH_80 : PH_FILL;
          if (fill_q == {sha256md_pkg::FillW{1'b1}}) begin
            rc.load = 1'b1;
            rnd_d   = '0;
            state_d = S_RND;
          end else if (msg_i.final_word) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        sc.push = 1'b1;
        fill_d  = fill_q + 1'b1;
        case (ph_q)
          PH_80: begin
            sc.word = 32'h8000_0000;
            ph_d    = PH_FILL;
          end
          PH_FILL: begin
            if (fill_q == 4'd14) begin
              sc.word = len_q[63:32];
              ph_d    = PH_LO;
            end else begin
              sc.word = '0;
            end
          end
          PH_LO: begin
            sc.word = len_q[31:0];
            ph_d    = PH_DONE;
          end
          default: begin
            sc.push = 1'b0;
            fill_d  = fill_q;
          end
        endcase
        if (sc.push && fill_q == {sha256md_pkg::FillW{1'b1}}) begin
          rc.load = 1'b1;
          rnd_d   = '0;
          state_d = S_RND;
        end
      end
      S_RND: begin
        rc.step = 1'b1;
        sc.step = 1'b1;
        rnd_d   = rnd_q + 1'b1;
        if (rnd_q == {sha256md_pkg::RoundW{1'b1}}) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
          h_d[i] = h_q[i] + vars[i];
        end
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (ph_q == PH_DONE) begin
          pos_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_PAD;
        end
      end
      S_OUT: begin
        if (dig_o.ready) begin
          // Shift the digest out and the initial hash in behind it.
          for (int i = 0; i < sha256md_pkg::NumHash - 1; i++) begin
            h_d[i] = h_q[i+1];
          end
          h_d[sha256md_pkg::NumHash-1] = sha256md_pkg::HashInit[pos_q];
          pos_d = pos_q + 1'b1;
          if (pos_q == {sha256md_pkg::PosW{1'b1}}) begin
            fin_d   = 1'b0;
            fill_d  = '0;
            len_d   = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_FILL;
      fin_q   <= 1'b0;
      fill_q  <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      pos_q   <= '0;
      h_q     <= sha256md_pkg::HashInit;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      fin_q   <= fin_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      rnd_q   <= rnd_d;
      pos_q   <= pos_d;
      h_q     <= h_d;
    end
  end

  // Drive the channels.
  assign msg_i.ready          = (state_q == S_IDLE);
  assign dig_o.valid          = (state_q == S_OUT);
  assign dig_o.digest_word    = h_q[0];
  assign dig_o.word_position  = pos_q;
  assign dig_o.last_of_digest = (pos_q == {sha256md_pkg::PosW{1'b1}});

endmodule

>>> sv/sha256md_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on word flow through the digest block.
module sha256md_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            in_final_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            out_last_i,
  input logic [sha256md_pkg::WordW-1:0]  out_digest_i,
  input logic [sha256md_pkg::PosW-1:0]   out_pos_i
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Never take a message word while a digest is being emitted.
  `SHA_ASSERT_IMP(a_no_in_during_out, clk_i, rst_ni, out_valid_i, !in_ready_i)
  // Hold off input once a final word is taken.
  `SHA_ASSERT_NXT(a_final_blocks, clk_i, rst_ni, in_fire && in_final_i, !in_ready_i)
  // Keep the digest run going until its last word.
  `SHA_ASSERT_NXT(a_run_continues, clk_i, rst_ni, out_fire && !out_last_i, out_valid_i)
  // Return to accepting words after the last digest word.
  `SHA_ASSERT_NXT(a_back_to_idle, clk_i, rst_ni, out_fire && out_last_i, in_ready_i && !out_valid_i)
  // Hold a stalled digest word.
  `SHA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_digest_i) && $stable(out_pos_i))

endmodule

bind sha256_message_digest sha256md_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (msg_i.valid),
  .in_ready_i   (msg_i.ready),
  .in_final_i   (msg_i.final_word),
  .out_valid_i  (dig_o.valid),
  .out_ready_i  (dig_o.ready),
  .out_last_i   (dig_o.last_of_digest),
  .out_digest_i (dig_o.digest_word),
  .out_pos_i    (dig_o.word_position)
);
